// ----- sv/sks_pkg.sv -----
// Shared types for the stable key/tag insertion sorter.
package sks_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } sks_item_t;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } sks_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } sks_state_t;

endpackage

// ----- sv/sks_cell.sv -----
// One cell of the sorting chain: holds one item and trades with its neighbors.
module sks_cell (
  input  logic                   clk,
  input  sks_pkg::sks_cell_ctrl_t ctrl,
  input  logic                   occupied,
  input  sks_pkg::sks_item_t     new_item,
  input  logic                   prev_goes,
  input  sks_pkg::sks_item_t     prev_item,
  input  sks_pkg::sks_item_t     next_item,
  output logic                   goes,
  output sks_pkg::sks_item_t     item_r
);
  import sks_pkg::*;

  sks_item_t item_nxt;

  // The new item lands ahead of this one only on a strictly smaller key, which keeps ties in
  // arrival order.
  assign goes = !occupied || (new_item.key < item_r.key);

  always_comb begin
    item_nxt = item_r;
    if (ctrl.shift_en) begin
      item_nxt = next_item;
    end else if (ctrl.ins_en && goes) begin
      item_nxt = prev_goes ? prev_item : new_item;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// ----- sv/stable_key_tag_sorter.sv -----
// Top level of the stable key/tag sorter built as an insertion cell chain.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_sort_key, in_item_tag, in_is_last
//   out     | output    | out_valid, out_ready, out_key, out_tag, out_last, out_overflowed
//
// While loading, one item is accepted every cycle; unless the chain is full, it is inserted into
// its sorted place at once, else dropped. The cycle after the last item is accepted, the chain
// drains one item per cycle from cell 0 while out_ready is high; input is held off meanwhile.
// A stalled output holds the chain in place. Reset clears the count, the drop flag and the state.
module stable_key_tag_sorter #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sort_key,
  input  logic [15:0] in_item_tag,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_key,
  output logic [15:0] out_tag,
  output logic        out_last,
  output logic        out_overflowed
);
  import sks_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  sks_state_t     state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           drop_r, drop_nxt;
  logic           in_acc, out_acc, full;
  sks_cell_ctrl_t ctrl;
  sks_item_t      new_item;
  sks_item_t      cell_item [CAPACITY];
  logic [CAPACITY-1:0] cell_goes;

  assign full     = (count_r == CW'(CAPACITY));
  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (state_r == ST_DRAIN);
  assign out_acc  = out_valid && out_ready;

  assign new_item = '{key: in_sort_key, tag: in_item_tag};

  assign ctrl = '{ins_en: in_acc && !full, shift_en: out_acc};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sks_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (count_r > CW'(i)),
      .new_item  (new_item),
      .prev_goes ((i == 0) ? 1'b0 : cell_goes[(i == 0) ? 0 : i - 1]),
      .prev_item (cell_item[(i == 0) ? 0 : i - 1]),
      .next_item ((i == CAPACITY - 1) ? new_item : cell_item[(i == CAPACITY - 1) ? i : i + 1]),
      .goes      (cell_goes[i]),
      .item_r    (cell_item[i])
    );
  end

  assign out_key        = cell_item[0].key;
  assign out_tag        = cell_item[0].tag;
  assign out_last       = (count_r == CW'(1));
  assign out_overflowed = drop_r && out_last;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_is_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - CW'(1);
          if (out_last) begin
            state_nxt = ST_LOAD;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// ----- sv/sks_checker.sv -----
// Port-level assertions for the stable key/tag sorter and their bind.
module sks_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_key,
  input logic [15:0] out_tag,
  input logic        out_last,
  input logic        out_overflowed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
      && $stable(out_last))
    else $error("Stalled output item changed.");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input taken while draining.");

  a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> out_valid && !in_ready)
    else $error("Drain did not start after the last item.");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("Loading did not resume after the final item.");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> out_last)
    else $error("Overflow flag on an item other than the final one.");

endmodule

bind stable_key_tag_sorter sks_checker u_sks_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_is_last     (in_is_last),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_key        (out_key),
  .out_tag        (out_tag),
  .out_last       (out_last),
  .out_overflowed (out_overflowed)
);
